>>> sv/q2r_pkg.sv
// Shared types and constants for the quaternion to rotation matrix block.
package q2r_pkg;

    localparam int FracBitsDef = 14;
    localparam int QW          = 18;
    localparam int SW          = 37;
    localparam int OW          = 16;
    localparam int NumEnt      = 9;
    localparam int QDepth      = 4;
    localparam int QAw         = 2;
    localparam int PAw         = 2;
    localparam logic [PAw-1:0] RegTol = 2'd0;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
        logic [SW-1:0]        s;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> sv/q2r_front.sv
// Front end: takes quaternion requests, forms squares and the sum of squares.
module q2r_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [4*q2r_pkg::QW-1:0] i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    input  q2r_pkg::t_qstat         i_qstat,
    output logic                    o_push,
    output q2r_pkg::t_item          o_item
);

    localparam int QW = q2r_pkg::QW;
    localparam int SW = q2r_pkg::SW;

    logic                 r_valid;
    logic signed [QW-1:0] r_w, r_x, r_y, r_z;
    logic [2*QW-1:0]      r_ww, r_xx, r_yy, r_zz;
    logic signed [QW-1:0] n_w, n_x, n_y, n_z;
    logic                 fen;

    assign fen        = !r_valid || !i_qstat.full;
    assign o_s_tready = fen;
    assign n_w = $signed(i_s_tdata[0*QW +: QW]);
    assign n_x = $signed(i_s_tdata[1*QW +: QW]);
    assign n_y = $signed(i_s_tdata[2*QW +: QW]);
    assign n_z = $signed(i_s_tdata[3*QW +: QW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (fen) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen && i_s_tvalid) begin
            r_w  <= n_w;
            r_x  <= n_x;
            r_y  <= n_y;
            r_z  <= n_z;
            r_ww <= (2*QW)'(n_w * n_w);
            r_xx <= (2*QW)'(n_x * n_x);
            r_yy <= (2*QW)'(n_y * n_y);
            r_zz <= (2*QW)'(n_z * n_z);
        end
    end

    assign o_push   = r_valid && !i_qstat.full;
    assign o_item.w = r_w;
    assign o_item.x = r_x;
    assign o_item.y = r_y;
    assign o_item.z = r_z;
    assign o_item.s = SW'(r_ww) + SW'(r_xx) + SW'(r_yy) + SW'(r_zz);

endmodule

>>> sv/q2r_queue.sv
// Short FIFO between the front end and the arithmetic back end.
module q2r_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  q2r_pkg::t_item  i_item,
    input  logic            i_pop,
    output q2r_pkg::t_item  o_item,
    output q2r_pkg::t_qstat o_qstat
);

    localparam int DEPTH = q2r_pkg::QDepth;
    localparam int AW    = q2r_pkg::QAw;

    q2r_pkg::t_item r_mem [0:DEPTH-1];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_qstat.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_item        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty) else $error("pop from empty queue");

endmodule

>>> sv/q2r_back.sv
// Back end: square root, normalizing division, matrix products, rounding.
module q2r_back #(
    parameter int FRAC_BITS = q2r_pkg::FracBitsDef
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  q2r_pkg::t_item                        i_item,
    output logic                                  o_pop,
    input  logic [7:0]                            i_tol,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [q2r_pkg::NumEnt*q2r_pkg::OW-1:0] o_m_tdata,
    output logic                                  o_m_tuser
);

    localparam int QW   = q2r_pkg::QW;
    localparam int OW   = q2r_pkg::OW;
    localparam int NE   = q2r_pkg::NumEnt;
    localparam int NS   = (q2r_pkg::SW + 1) / 2;
    localparam int RW   = NS + 3;
    localparam int NDIV = FRAC_BITS + 2;
    localparam int DW   = FRAC_BITS + 21;
    localparam int TW   = (FRAC_BITS + 2 > NS + 1) ? FRAC_BITS + 2 : NS + 1;
    localparam int CW   = (FRAC_BITS + 3 > QW + 1) ? FRAC_BITS + 3 : QW + 1;
    localparam int PW   = 2 * CW;
    localparam int EW   = PW + 3;

    logic en;
    assign en    = !o_m_tvalid || i_m_tready;
    assign o_pop = en && i_vld;

    // square root, one result bit per stage
    logic           r_sq_v    [0:NS];
    logic [RW-1:0]  r_sq_rem  [0:NS];
    logic [NS-1:0]  r_sq_root [0:NS];
    q2r_pkg::t_item r_sq_it   [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= i_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_it[0]   <= i_item;
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_sq
        localparam int PB = 2 * (NS - k);
        logic [2*NS-1:0] s2;
        logic [RW-1:0]   rem_sh, trial;
        logic            ge;
        assign s2     = (2*NS)'(r_sq_it[k-1].s);
        assign rem_sh = {r_sq_rem[k-1][RW-3:0], s2[PB +: 2]};
        assign trial  = RW'({r_sq_root[k-1], 2'b01});
        assign ge     = rem_sh >= trial;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (en) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k]  <= ge ? rem_sh - trial : rem_sh;
                r_sq_root[k] <= {r_sq_root[k-1][NS-2:0], ge};
                r_sq_it[k]   <= r_sq_it[k-1];
            end
        end
    end

    // tolerance check and numerators
    logic [NS-1:0]  norm;
    logic [TW-1:0]  norm_e, one_e, dev;
    logic           skip;
    logic [QW-1:0]  raw [0:3];
    logic           neg [0:3];
    logic [DW-1:0]  num [0:3];

    assign norm   = r_sq_root[NS];
    assign norm_e = TW'(norm);
    assign one_e  = TW'(1) << FRAC_BITS;
    assign dev    = (norm_e >= one_e) ? norm_e - one_e : one_e - norm_e;
    assign skip   = dev < TW'(i_tol);
    assign raw[0] = r_sq_it[NS].w;
    assign raw[1] = r_sq_it[NS].x;
    assign raw[2] = r_sq_it[NS].y;
    assign raw[3] = r_sq_it[NS].z;

    for (genvar c = 0; c < 4; c++) begin : g_num
        logic [QW-1:0] mag;
        assign neg[c] = raw[c][QW-1];
        assign mag    = neg[c] ? QW'(-raw[c]) : raw[c];
        assign num[c] = (DW'(mag) << FRAC_BITS) + DW'(norm >> 1);
    end

    // restoring division, one quotient bit per stage
    logic           r_dv_v    [0:NDIV];
    logic [DW-1:0]  r_dv_r    [0:NDIV][0:3];
    logic [NDIV-1:0] r_dv_q   [0:NDIV][0:3];
    logic           r_dv_neg  [0:NDIV][0:3];
    logic [NS-1:0]  r_dv_norm [0:NDIV];
    logic           r_dv_skip [0:NDIV];
    q2r_pkg::t_item r_dv_it   [0:NDIV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_sq_v[NS];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r_dv_r[0][c]   <= num[c];
                r_dv_q[0][c]   <= '0;
                r_dv_neg[0][c] <= neg[c];
            end
            r_dv_norm[0] <= norm;
            r_dv_skip[0] <= skip;
            r_dv_it[0]   <= r_sq_it[NS];
        end
    end

    for (genvar j = 1; j <= NDIV; j++) begin : g_dv
        localparam int SH = NDIV - j;
        logic [DW-1:0] dsh;
        assign dsh = DW'(r_dv_norm[j-1]) << SH;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (en) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int c = 0; c < 4; c++) begin
                    if (r_dv_r[j-1][c] >= dsh) begin
                        r_dv_r[j][c] <= r_dv_r[j-1][c] - dsh;
                        r_dv_q[j][c] <= {r_dv_q[j-1][c][NDIV-2:0], 1'b1};
                    end else begin
                        r_dv_r[j][c] <= r_dv_r[j-1][c];
                        r_dv_q[j][c] <= {r_dv_q[j-1][c][NDIV-2:0], 1'b0};
                    end
                    r_dv_neg[j][c] <= r_dv_neg[j-1][c];
                end
                r_dv_norm[j] <= r_dv_norm[j-1];
                r_dv_skip[j] <= r_dv_skip[j-1];
                r_dv_it[j]   <= r_dv_it[j-1];
            end
        end
    end

    // select normalized or raw components
    logic                 r_e_v, r_e_zero;
    logic signed [CW-1:0] r_e_c [0:3];
    logic [QW-1:0]        raw_d [0:3];

    assign raw_d[0] = r_dv_it[NDIV].w;
    assign raw_d[1] = r_dv_it[NDIV].x;
    assign raw_d[2] = r_dv_it[NDIV].y;
    assign raw_d[3] = r_dv_it[NDIV].z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (en) begin
            r_e_v <= r_dv_v[NDIV];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_zero <= (r_dv_it[NDIV].s == '0);
            for (int c = 0; c < 4; c++) begin
                if (r_dv_skip[NDIV]) begin
                    r_e_c[c] <= CW'($signed(raw_d[c]));
                end else if (r_dv_neg[NDIV][c]) begin
                    r_e_c[c] <= -$signed(CW'(r_dv_q[NDIV][c]));
                end else begin
                    r_e_c[c] <= $signed(CW'(r_dv_q[NDIV][c]));
                end
            end
        end
    end

    // products: w=0 x=1 y=2 z=3
    logic                 r_f_v, r_f_zero;
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (en) begin
            r_f_v <= r_e_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_zero <= r_e_zero;
            r_xx <= r_e_c[1] * r_e_c[1];
            r_yy <= r_e_c[2] * r_e_c[2];
            r_zz <= r_e_c[3] * r_e_c[3];
            r_xy <= r_e_c[1] * r_e_c[2];
            r_xz <= r_e_c[1] * r_e_c[3];
            r_yz <= r_e_c[2] * r_e_c[3];
            r_wx <= r_e_c[0] * r_e_c[1];
            r_wy <= r_e_c[0] * r_e_c[2];
            r_wz <= r_e_c[0] * r_e_c[3];
        end
    end

    // matrix entries in Q.2F
    logic                 r_g_v, r_g_zero;
    logic signed [EW-1:0] r_g_e [0:NE-1];
    logic signed [EW-1:0] one2;
    logic signed [EW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

    assign one2 = EW'(1) <<< (2 * FRAC_BITS);
    assign xx = EW'(r_xx);
    assign yy = EW'(r_yy);
    assign zz = EW'(r_zz);
    assign xy = EW'(r_xy);
    assign xz = EW'(r_xz);
    assign yz = EW'(r_yz);
    assign wx = EW'(r_wx);
    assign wy = EW'(r_wy);
    assign wz = EW'(r_wz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (en) begin
            r_g_v <= r_f_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_zero <= r_f_zero;
            r_g_e[0] <= one2 - ((yy + zz) <<< 1);
            r_g_e[1] <= (xy - wz) <<< 1;
            r_g_e[2] <= (xz + wy) <<< 1;
            r_g_e[3] <= (xy + wz) <<< 1;
            r_g_e[4] <= one2 - ((xx + zz) <<< 1);
            r_g_e[5] <= (yz - wx) <<< 1;
            r_g_e[6] <= (xz - wy) <<< 1;
            r_g_e[7] <= (yz + wx) <<< 1;
            r_g_e[8] <= one2 - ((xx + yy) <<< 1);
        end
    end

    // round half away from zero, saturate to +-one
    function automatic logic [OW-1:0] finish(input logic signed [EW-1:0] v);
        logic [EW-1:0]        mag;
        logic [EW-1:0]        q;
        logic signed [EW-1:0] r;
        logic signed [EW-1:0] one;
        mag = v[EW-1] ? EW'(-v) : EW'(v);
        q   = (mag + (EW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        one = EW'(1) <<< FRAC_BITS;
        r   = v[EW-1] ? -$signed(q) : $signed(q);
        if (r > one) begin
            r = one;
        end
        if (r < -one) begin
            r = -one;
        end
        return r[OW-1:0];
    endfunction

    logic          r_out_v, r_out_zero;
    logic [OW-1:0] r_out_e [0:NE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_g_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_zero <= r_g_zero;
            for (int i = 0; i < NE; i++) begin
                r_out_e[i] <= r_g_zero ? '0 : finish(r_g_e[i]);
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_zero;
    for (genvar i = 0; i < NE; i++) begin : g_pack
        assign o_m_tdata[i*OW +: OW] = r_out_e[i];
    end

    a_zero_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_zero) |-> (o_m_tdata == '0))
        else $error("zero-norm result with nonzero entries");

endmodule

>>> sv/quaternion_to_rotation_matrix.sv
// Throughput: one quaternion per cycle while the result side is not stalled; the square root (19 stages) and the
// divider (FRAC_BITS + 2 stages) are fully pipelined, one result bit per stage.
// A four-entry queue decouples the front end from the arithmetic pipeline.
// Synchronous active-low reset clears all valid state and unit_tolerance to 0.
module quaternion_to_rotation_matrix #(
    parameter int FRAC_BITS = q2r_pkg::FracBitsDef
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [4*q2r_pkg::QW-1:0]              i_s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [q2r_pkg::NumEnt*q2r_pkg::OW-1:0] o_m_tdata, // m00 m01 m02 m10 m11 m12 m20 m21 m22
    output logic                                  o_m_tuser,  // zero_norm
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [q2r_pkg::PAw-1:0]               paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic [7:0]      r_tol;
    logic            push, pop;
    q2r_pkg::t_item  f_item, q_item;
    q2r_pkg::t_qstat qstat;

    assign pready = 1'b1;
    assign prdata = (paddr == q2r_pkg::RegTol) ? {24'd0, r_tol} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_tol <= pwdata[7:0];
        end
    end

    q2r_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_item     (f_item)
    );

    q2r_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_qstat (qstat)
    );

    q2r_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (!qstat.empty),
        .i_item     (q_item),
        .o_pop      (pop),
        .i_tol      (r_tol),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

>>> tb/sv/quaternion_to_rotation_matrix_tb.sv
// Stream testbench for the quaternion to rotation matrix block, with its own matrix predictor.
class matrix_scoreboard;
    typedef struct {
        logic [15:0] ent [9];
        logic        zflag;
    } t_matrix;

    t_matrix     pending[$];
    logic [7:0]  tol;
    int          errors;

    function new();
        tol    = 8'd0;
        errors = 0;
    endfunction

    static function longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    static function logic [15:0] to_entry(longint v);
        longint r;
        r = round_div(v, 64'sd16384);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    static function longint int_sqrt(longint s);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd371000;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= s) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function void note_quat(logic signed [17:0] qw, logic signed [17:0] qx,
                            logic signed [17:0] qy, logic signed [17:0] qz);
        t_matrix m;
        longint  w, x, y, z, s, n, d, one;
        w = qw; x = qx; y = qy; z = qz;
        one = 16384;
        s = w * w + x * x + y * y + z * z;
        if (s == 0) begin
            foreach (m.ent[k]) m.ent[k] = '0;
            m.zflag = 1'b1;
        end else begin
            n = int_sqrt(s);
            d = (n >= one) ? n - one : one - n;
            if (!(d < tol)) begin
                w = round_div(w * one, n);
                x = round_div(x * one, n);
                y = round_div(y * one, n);
                z = round_div(z * one, n);
            end
            m.ent[0] = to_entry(one * one - 2 * (y * y + z * z));
            m.ent[1] = to_entry(2 * (x * y - w * z));
            m.ent[2] = to_entry(2 * (x * z + w * y));
            m.ent[3] = to_entry(2 * (x * y + w * z));
            m.ent[4] = to_entry(one * one - 2 * (x * x + z * z));
            m.ent[5] = to_entry(2 * (y * z - w * x));
            m.ent[6] = to_entry(2 * (x * z - w * y));
            m.ent[7] = to_entry(2 * (y * z + w * x));
            m.ent[8] = to_entry(one * one - 2 * (x * x + y * y));
            m.zflag  = 1'b0;
        end
        pending.push_back(m);
    endfunction

    function void check_matrix(logic [143:0] data, logic zflag);
        t_matrix m;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result data=%h flag=%b", $time, data, zflag);
            errors++;
            return;
        end
        m = pending.pop_front();
        for (int k = 0; k < 9; k++)
            if (data[16*k +: 16] !== m.ent[k]) begin
                $display("%0t: entry %0d expected %h actual %h", $time, k, m.ent[k],
                         data[16*k +: 16]);
                errors++;
            end
        if (zflag !== m.zflag) begin
            $display("%0t: zero_norm expected %b actual %b", $time, m.zflag, zflag);
            errors++;
        end
    endfunction
endclass

module quaternion_to_rotation_matrix_tb;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [71:0]    i_s_tdata = '0;  // quat_w, quat_x, quat_y, quat_z
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    logic [143:0]   o_m_tdata;       // m00 m01 m02 m10 m11 m12 m20 m21 m22
    logic           o_m_tuser;       // zero_norm
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [q2r_pkg::PAw-1:0] paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    matrix_scoreboard board = new();
    bit     calm = 1'b0;
    bit     hold_sink = 1'b0;
    longint cycles = 0;

    quaternion_to_rotation_matrix dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && i_s_tvalid && o_s_tready)
            board.note_quat(i_s_tdata[17:0], i_s_tdata[35:18], i_s_tdata[53:36],
                            i_s_tdata[71:54]);

    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_matrix(o_m_tdata, o_m_tuser);

    // result side: random stall bursts, plus one long hold-off
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_tready <= 1'b0;
                repeat (200) @(negedge i_clk);
                hold_sink = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic write_tol(logic [7:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= q2r_pkg::RegTol; pwdata <= {24'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.tol = v;
    endtask

    task automatic send_quat(logic [17:0] w, logic [17:0] x, logic [17:0] y, logic [17:0] z);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {z, y, x, w};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [17:0] rand_comp(int mode);
        case (mode)
            0: return 18'($urandom);
            1: return 18'($signed($urandom_range(0, 16384)) - 8192);
            default: return 18'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_run(int n);
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 2);
            if ($urandom_range(0, 15) == 0)
                send_quat(18'd16384 + 18'($urandom_range(0, 400)) - 18'd200, 18'd0,
                          rand_comp(1) >>> 6, 18'd0);
            else
                send_quat(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: identity, axes, zero, extremes, equal components
        send_quat(18'd16384, 18'd0, 18'd0, 18'd0);
        send_quat(18'd0, 18'd16384, 18'd0, 18'd0);
        send_quat(18'd0, 18'd0, 18'd16384, 18'd0);
        send_quat(18'd0, 18'd0, 18'd0, 18'd16384);
        send_quat(18'd0, 18'd0, 18'd0, 18'd0);
        send_quat(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        send_quat(18'h20000, 18'h20000, 18'h20000, 18'h20000);
        send_quat(18'h20000, 18'd0, 18'd0, 18'd0);
        send_quat(18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000);
        send_quat(18'd0, 18'd0, 18'd0, 18'd1);
        send_quat(18'h3FFFF, 18'd0, 18'd0, 18'd0);
        send_quat(18'd8192, 18'd8192, 18'd8192, 18'd8192);
        send_quat(18'd16390, 18'd100, 18'd0, 18'd0);
        random_run(120);
        drain();
        write_tol(8'd255);
        send_quat(18'd16384 + 18'd254, 18'd0, 18'd0, 18'd0);
        send_quat(18'd16384 + 18'd255, 18'd0, 18'd0, 18'd0);
        send_quat(18'd16384 - 18'd254, 18'd3, 18'd0, 18'd0);
        send_quat(18'd8192, 18'd8192, 18'd8192, 18'd8192);
        send_quat(18'd0, 18'd0, 18'd0, 18'd0);
        random_run(140);
        hold_sink = 1'b1;
        random_run(40);
        drain();
        write_tol(8'd1);
        random_run(120);
        drain();
        write_tol(8'd37);
        calm = 1'b1;
        random_run(120);
        drain();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> files.f
sv/q2r_pkg.sv
sv/q2r_front.sv
sv/q2r_queue.sv
sv/q2r_back.sv
sv/quaternion_to_rotation_matrix.sv
tb/sv/quaternion_to_rotation_matrix_tb.sv
